@@ rtl/lodsg_pkg.sv @@
// Shared types and constants of the LOD stitching index generator.
// No dependencies; every other file of the block but lodsg_ram imports this package.
`default_nettype none

package lodsg_pkg;

   localparam int GRID_CELLS_DEF = 64;
   localparam int IDX_W          = 13;
   localparam int LOD_W          = 3;
   localparam int REGION_W       = 3;
   localparam int EPOCH_W        = 6;

   localparam logic [LOD_W-1:0] LOD_MAX = 3'd5;

   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_ADVANCE = 1'b1;

   localparam int FLAG_NORTH = 0;
   localparam int FLAG_SOUTH = 1;
   localparam int FLAG_EAST  = 2;
   localparam int FLAG_WEST  = 3;

   localparam logic [REGION_W-1:0] REGION_NORTH = 3'd0;
   localparam logic [REGION_W-1:0] REGION_SOUTH = 3'd1;
   localparam logic [REGION_W-1:0] REGION_EAST  = 3'd2;
   localparam logic [REGION_W-1:0] REGION_WEST  = 3'd3;
   localparam logic [REGION_W-1:0] REGION_FILL  = 3'd4;

   // list walk position: which boundary or the interior is being meshed
   typedef enum logic [6:0] {
      PH_IDLE  = 7'b0000001,
      PH_NORTH = 7'b0000010,
      PH_SOUTH = 7'b0000100,
      PH_EAST  = 7'b0001000,
      PH_WEST  = 7'b0010000,
      PH_FILL  = 7'b0100000,
      PH_DONE  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic             func;
      logic [LOD_W-1:0] lod_north;
      logic [LOD_W-1:0] lod_south;
      logic [LOD_W-1:0] lod_east;
      logic [LOD_W-1:0] lod_west;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]    index_first;
      logic [IDX_W-1:0]    index_second;
      logic [IDX_W-1:0]    index_third;
      logic [REGION_W-1:0] region;
      logic                last;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] tri_idx;
   } tri_sel_type;

endpackage

`default_nettype wire

@@ rtl/lodsg_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module lodsg_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/lodsg_vertex_sel.sv @@
// Vertex selection: turns a group base index and the grid width into the
// three clockwise vertex indices of one triangle. Depends on lodsg_pkg.
`default_nettype none

module lodsg_vertex_sel
   import lodsg_pkg::*;
(
   input  logic [IDX_W-1:0] base,
   input  logic [IDX_W-1:0] width,
   input  tri_sel_type      sel,
   output logic [IDX_W-1:0] vtx_first,
   output logic [IDX_W-1:0] vtx_second,
   output logic [IDX_W-1:0] vtx_third
);

   logic [IDX_W-1:0] o_0, o_1, o_2, o_w, o_w1, o_w2, o_2w, o_2w1;

   // all sums wrap at the index width, as the output fields do
   assign o_0   = base;
   assign o_1   = base + IDX_W'(1);
   assign o_2   = base + IDX_W'(2);
   assign o_w   = base + width;
   assign o_w1  = o_w + IDX_W'(1);
   assign o_w2  = o_w + IDX_W'(2);
   assign o_2w  = o_w + width;
   assign o_2w1 = o_2w + IDX_W'(1);

   always_comb begin
      vtx_first  = o_0;
      vtx_second = o_w;
      vtx_third  = o_1;
      case (sel.phase)
         PH_NORTH: begin
            case (sel.tri_idx)
               2'd0: begin vtx_first = o_0; vtx_second = o_w;  vtx_third = o_1;  end
               2'd1: begin vtx_first = o_1; vtx_second = o_w;  vtx_third = o_w2; end
               default: begin vtx_first = o_1; vtx_second = o_w2; vtx_third = o_2; end
            endcase
         end
         PH_SOUTH: begin
            case (sel.tri_idx)
               2'd0: begin vtx_first = o_0; vtx_second = o_w;  vtx_third = o_w1; end
               2'd1: begin vtx_first = o_0; vtx_second = o_w1; vtx_third = o_2;  end
               default: begin vtx_first = o_2; vtx_second = o_w1; vtx_third = o_w2; end
            endcase
         end
         PH_EAST: begin
            case (sel.tri_idx)
               2'd0: begin vtx_first = o_0; vtx_second = o_w;   vtx_third = o_1; end
               2'd1: begin vtx_first = o_w; vtx_second = o_2w1; vtx_third = o_1; end
               default: begin vtx_first = o_w; vtx_second = o_2w; vtx_third = o_2w1; end
            endcase
         end
         PH_WEST: begin
            case (sel.tri_idx)
               2'd0: begin vtx_first = o_0; vtx_second = o_w1; vtx_third = o_1;  end
               2'd1: begin vtx_first = o_0; vtx_second = o_2w; vtx_third = o_w1; end
               default: begin vtx_first = o_2w; vtx_second = o_2w1; vtx_third = o_w1; end
            endcase
         end
         default: begin
            // interior cell: two triangles per quad
            if (sel.tri_idx == 2'd0) begin
               vtx_first = o_0; vtx_second = o_w; vtx_third = o_1;
            end else begin
               vtx_first = o_1; vtx_second = o_w; vtx_third = o_w1;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/lod_stitch_index_generator.sv @@
// Top level of the LOD stitching index generator; uses lodsg_pkg, lodsg_ram, lodsg_vertex_sel.
// One item is in work at a time and ready is low meanwhile. An advance inside a group passes
// BASE, MAC, EMIT, OUT (waiting for a free result register); opening a group adds the
// settle walk, closing one adds the walk plus, for a fan, MAC and WR per cell mark; a start
// runs the walk. Walk: a SETTLE step per skipped edge or row wrap, MAC, RD, CHK per map lookup.
// Reset (sync, active high) and every epoch-wrapping start wipe all (GRID_CELLS+1)^2 map entries.
`default_nettype none

module lod_stitch_index_generator
   import lodsg_pkg::*;
#(
   parameter int GRID_CELLS = GRID_CELLS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp,
   input  logic             csr_wr_en,
   input  logic [LOD_W-1:0] csr_wr_data
);

   // Widths that follow from the grid size.
   localparam int NW        = $clog2(GRID_CELLS + 1);   // cells per side
   localparam int WW        = $clog2(GRID_CELLS + 2);   // vertices per side
   localparam int CUR_W     = $clog2(GRID_CELLS + 1);   // cursor
   localparam int MAP_DEPTH = (GRID_CELLS + 1) * (GRID_CELLS + 1);
   localparam int AW        = $clog2(MAP_DEPTH);
   localparam int MW        = (AW > IDX_W) ? AW : IDX_W; // multiply-add width

   // Sequencer. SETTLE walks the cursor to the next group that yields
   // triangles; MAC is the one shared multiply-add (row * width + col) used
   // for map addresses and for the group base index.
   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b0000000001,
      ST_IDLE   = 10'b0000000010,
      ST_SETTLE = 10'b0000000100,
      ST_MAC    = 10'b0000001000,
      ST_RD     = 10'b0000010000,
      ST_CHK    = 10'b0000100000,
      ST_BASE   = 10'b0001000000,
      ST_EMIT   = 10'b0010000000,
      ST_WR     = 10'b0100000000,
      ST_OUT    = 10'b1000000000
   } st_type;

   // where the settle walk returns to
   typedef enum logic [1:0] {
      CTX_START = 2'd0,
      CTX_PRE   = 2'd1,
      CTX_POST  = 2'd2
   } ctx_type;

   // what the multiply-add result is for
   typedef enum logic [1:0] {
      USE_READ  = 2'd0,
      USE_WRITE = 2'd1,
      USE_BASE  = 2'd2
   } use_type;

   function automatic st_type after_settle(input ctx_type ctx, input phase_type ph);
      st_type res;
      case (ctx)
         CTX_START: res = ST_IDLE;
         CTX_PRE:   res = (ph == PH_DONE) ? ST_IDLE : ST_BASE;
         CTX_POST:  res = ST_OUT;
         default:   res = ST_IDLE;
      endcase
      return res;
   endfunction

   function automatic logic [REGION_W-1:0] region_of(input phase_type ph);
      logic [REGION_W-1:0] res;
      case (ph)
         PH_NORTH: res = REGION_NORTH;
         PH_SOUTH: res = REGION_SOUTH;
         PH_EAST:  res = REGION_EAST;
         PH_WEST:  res = REGION_WEST;
         default:  res = REGION_FILL;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   logic [LOD_W-1:0]   csr_ff;
   st_type             st_ff, st_in;
   phase_type          phase_ff, phase_in;
   logic [3:0]         flags_ff, flags_in;
   logic [CUR_W-1:0]   col_ff, col_in, row_ff, row_in;
   logic [1:0]         tig_ff, tig_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   ctx_type            ctx_ff, ctx_in;
   use_type            use_ff, use_in;
   logic               sel_ff, sel_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               clr_go_ff, clr_go_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [MW-1:0]      opa_ff, opa_in, opb_ff, opb_in, mac_ff, mac_in;
   logic               inrange_ff, inrange_in;
   rsp_type            tri_ff, tri_in, rsp_ff, rsp_in;

   // ---------------------------------------------------------------------
   // Grid geometry from the live level register
   // ---------------------------------------------------------------------
   logic [LOD_W-1:0] lod_used;
   logic [NW-1:0]    n_cells;
   logic [WW-1:0]    w_verts;
   logic [MW-1:0]    n_m, w_m, nm1_m, nm2_m, col_m, row_m;

   assign lod_used = (csr_ff > LOD_MAX) ? LOD_MAX : csr_ff;
   assign n_cells  = NW'(GRID_CELLS) >> lod_used;
   assign w_verts  = WW'(n_cells) + WW'(1);
   assign n_m      = MW'(n_cells);
   assign w_m      = MW'(w_verts);
   // n - 1 wraps when the grid is empty: out of range for marks, and the
   // wrapped value is what the index arithmetic needs
   assign nm1_m    = n_m - MW'(1);
   assign nm2_m    = n_m - MW'(2);
   assign col_m    = MW'(col_ff);
   assign row_m    = MW'(row_ff);

   // ---------------------------------------------------------------------
   // Processed-cell map: one epoch tag per entry, current when it matches
   // ---------------------------------------------------------------------
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [EPOCH_W-1:0] ram_wr_data, ram_rd_data;

   lodsg_ram #(
      .WIDTH (EPOCH_W),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (mac_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // Triangle vertices of the current group
   // ---------------------------------------------------------------------
   logic [IDX_W-1:0] vtx0, vtx1, vtx2;

   lodsg_vertex_sel u_vsel (
      .base       (mac_ff[IDX_W-1:0]),
      .width      (IDX_W'(w_verts)),
      .sel        (tri_sel_type'{phase: phase_ff, tri_idx: tig_ff}),
      .vtx_first  (vtx0),
      .vtx_second (vtx1),
      .vtx_third  (vtx2)
   );

   // ---------------------------------------------------------------------
   // Operand selection for the shared multiply-add (row operand cz, column cx)
   // ---------------------------------------------------------------------
   logic          mark_sel, read_sel;
   logic [MW-1:0] mk_cx, mk_cz, rd_cx, rd_cz, bs_cx, bs_cz;
   logic          mk_inrange;

   // second mark is issued from WR, second lookup from CHK
   assign mark_sel = (st_ff == ST_WR);
   assign read_sel = (st_ff == ST_CHK);

   always_comb begin
      mk_cx = '0;
      mk_cz = '0;
      rd_cx = col_m;
      rd_cz = row_m;
      bs_cx = col_m;
      bs_cz = row_m;
      case (phase_ff)
         PH_NORTH: begin
            mk_cx = col_m + MW'(mark_sel);
            mk_cz = nm1_m;
            bs_cz = nm1_m;
         end
         PH_SOUTH: begin
            mk_cx = col_m + MW'(mark_sel);
            bs_cz = '0;
         end
         PH_EAST: begin
            mk_cx = nm1_m;
            mk_cz = row_m + MW'(mark_sel);
            // the first east lookup probes one column in from the edge
            rd_cx = read_sel ? nm1_m : nm2_m;
            rd_cz = row_m + MW'(read_sel);
            bs_cx = nm1_m;
         end
         PH_WEST: begin
            mk_cz = row_m + MW'(mark_sel);
            rd_cx = '0;
            rd_cz = row_m + MW'(read_sel);
            bs_cx = '0;
         end
         default: begin
         end
      endcase
   end

   assign mk_inrange = (mk_cx < w_m) && (mk_cz < w_m);

   logic          hit;
   logic          group_done;
   logic [MW-1:0] mac_sum;

   assign hit        = (ram_rd_data == epoch_ff);
   assign group_done = (phase_ff == PH_FILL) ? (tig_ff == 2'd1) : (tig_ff == 2'd2);
   assign mac_sum    = opa_ff * w_m + opb_ff;

   // ---------------------------------------------------------------------
   // Next-state logic
   // ---------------------------------------------------------------------
   always_comb begin
      st_in        = st_ff;
      phase_in     = phase_ff;
      flags_in     = flags_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      tig_in       = tig_ff;
      epoch_in     = epoch_ff;
      ctx_in       = ctx_ff;
      use_in       = use_ff;
      sel_in       = sel_ff;
      clr_in       = clr_ff;
      clr_go_in    = clr_go_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      mac_in       = mac_ff;
      inrange_in   = inrange_ff;
      tri_in       = tri_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = mac_ff[AW-1:0];
      ram_wr_data  = epoch_ff;

      case (st_ff)
         ST_CLEAR: begin
            // wipe every tag to zero; the epoch in use is never zero
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            if (clr_ff == AW'(MAP_DEPTH - 1)) begin
               st_in = clr_go_ff ? ST_SETTLE : ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               if (req.func == FUNC_START) begin
                  flags_in[FLAG_NORTH] = req.lod_north > lod_used;
                  flags_in[FLAG_SOUTH] = req.lod_south > lod_used;
                  flags_in[FLAG_EAST]  = req.lod_east  > lod_used;
                  flags_in[FLAG_WEST]  = req.lod_west  > lod_used;
                  phase_in = PH_NORTH;
                  col_in   = '0;
                  row_in   = '0;
                  tig_in   = '0;
                  ctx_in   = CTX_START;
                  // a new epoch empties the map; on wrap, wipe it for real
                  if (epoch_ff == {EPOCH_W{1'b1}}) begin
                     epoch_in  = EPOCH_W'(1);
                     clr_in    = '0;
                     clr_go_in = 1'b1;
                     st_in     = ST_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + EPOCH_W'(1);
                     st_in    = ST_SETTLE;
                  end
               end else if (phase_ff == PH_IDLE || phase_ff == PH_DONE) begin
                  // drop the advance: nothing to emit
                  st_in = ST_IDLE;
               end else if (tig_ff == 2'd0) begin
                  ctx_in = CTX_PRE;
                  st_in  = ST_SETTLE;
               end else begin
                  st_in = ST_BASE;
               end
            end
         end

         ST_SETTLE: begin
            case (phase_ff)
               PH_NORTH: begin
                  if (!flags_ff[FLAG_NORTH] || (col_m + MW'(2)) > n_m) begin
                     phase_in = PH_SOUTH;
                     col_in   = '0;
                     row_in   = '0;
                  end else begin
                     st_in = after_settle(ctx_ff, phase_ff);
                  end
               end
               PH_SOUTH: begin
                  if (!flags_ff[FLAG_SOUTH] || (col_m + MW'(2)) > n_m) begin
                     phase_in = PH_EAST;
                     col_in   = '0;
                     row_in   = '0;
                  end else begin
                     st_in = after_settle(ctx_ff, phase_ff);
                  end
               end
               PH_EAST: begin
                  if (!flags_ff[FLAG_EAST] || (row_m + MW'(2)) > n_m) begin
                     phase_in = PH_WEST;
                     col_in   = '0;
                     row_in   = '0;
                  end else begin
                     opa_in = rd_cz;
                     opb_in = rd_cx;
                     use_in = USE_READ;
                     sel_in = 1'b0;
                     st_in  = ST_MAC;
                  end
               end
               PH_WEST: begin
                  if (!flags_ff[FLAG_WEST] || (row_m + MW'(2)) > n_m) begin
                     phase_in = PH_FILL;
                     col_in   = '0;
                     row_in   = '0;
                  end else begin
                     opa_in = rd_cz;
                     opb_in = rd_cx;
                     use_in = USE_READ;
                     sel_in = 1'b0;
                     st_in  = ST_MAC;
                  end
               end
               PH_FILL: begin
                  if (row_m >= n_m) begin
                     phase_in = PH_DONE;
                     st_in    = after_settle(ctx_ff, PH_DONE);
                  end else if (col_m >= n_m) begin
                     col_in = '0;
                     row_in = CUR_W'(row_m + MW'(1));
                  end else begin
                     opa_in = rd_cz;
                     opb_in = rd_cx;
                     use_in = USE_READ;
                     sel_in = 1'b0;
                     st_in  = ST_MAC;
                  end
               end
               default: begin
                  st_in = after_settle(ctx_ff, phase_ff);
               end
            endcase
         end

         ST_MAC: begin
            mac_in = mac_sum;
            case (use_ff)
               USE_READ:  st_in = ST_RD;
               USE_WRITE: st_in = ST_WR;
               default:   st_in = ST_EMIT;
            endcase
         end

         ST_RD: begin
            st_in = ST_CHK;
         end

         ST_CHK: begin
            if (phase_ff == PH_FILL) begin
               if (hit) begin
                  col_in = CUR_W'(col_m + MW'(1));
                  st_in  = ST_SETTLE;
               end else begin
                  st_in = after_settle(ctx_ff, phase_ff);
               end
            end else if (hit) begin
               // pair already covered by an earlier fan: skip it
               row_in = CUR_W'(row_m + MW'(2));
               st_in  = ST_SETTLE;
            end else if (!sel_ff) begin
               opa_in = rd_cz;
               opb_in = rd_cx;
               use_in = USE_READ;
               sel_in = 1'b1;
               st_in  = ST_MAC;
            end else begin
               st_in = after_settle(ctx_ff, phase_ff);
            end
         end

         ST_BASE: begin
            opa_in = bs_cz;
            opb_in = bs_cx;
            use_in = USE_BASE;
            st_in  = ST_MAC;
         end

         ST_EMIT: begin
            tri_in.index_first  = vtx0;
            tri_in.index_second = vtx1;
            tri_in.index_third  = vtx2;
            tri_in.region       = region_of(phase_ff);
            tri_in.last         = 1'b0;
            if (group_done) begin
               tig_in = '0;
               if (phase_ff == PH_FILL) begin
                  col_in = CUR_W'(col_m + MW'(1));
                  ctx_in = CTX_POST;
                  st_in  = ST_SETTLE;
               end else begin
                  opa_in     = mk_cz;
                  opb_in     = mk_cx;
                  inrange_in = mk_inrange;
                  use_in     = USE_WRITE;
                  sel_in     = 1'b0;
                  st_in      = ST_MAC;
               end
            end else begin
               tig_in = tig_ff + 2'd1;
               st_in  = ST_OUT;
            end
         end

         ST_WR: begin
            // mark the cell only when it lies inside the current grid
            ram_wr_en = inrange_ff;
            if (!sel_ff) begin
               opa_in     = mk_cz;
               opb_in     = mk_cx;
               inrange_in = mk_inrange;
               use_in     = USE_WRITE;
               sel_in     = 1'b1;
               st_in      = ST_MAC;
            end else begin
               if (phase_ff == PH_NORTH || phase_ff == PH_SOUTH) begin
                  col_in = CUR_W'(col_m + MW'(2));
               end else begin
                  row_in = CUR_W'(row_m + MW'(2));
               end
               ctx_in = CTX_POST;
               st_in  = ST_SETTLE;
            end
         end

         ST_OUT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = tri_ff;
               rsp_in.last  = (phase_ff == PH_DONE);
               rsp_valid_in = 1'b1;
               st_in        = ST_IDLE;
            end
         end

         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= '0;
         st_ff        <= ST_CLEAR;
         phase_ff     <= PH_IDLE;
         flags_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         tig_ff       <= '0;
         epoch_ff     <= '0;
         ctx_ff       <= CTX_START;
         use_ff       <= USE_READ;
         sel_ff       <= 1'b0;
         clr_ff       <= '0;
         clr_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         st_ff        <= st_in;
         phase_ff     <= phase_in;
         flags_ff     <= flags_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         tig_ff       <= tig_in;
         epoch_ff     <= epoch_in;
         ctx_ff       <= ctx_in;
         use_ff       <= use_in;
         sel_ff       <= sel_in;
         clr_ff       <= clr_in;
         clr_go_ff    <= clr_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      mac_ff     <= mac_in;
      inrange_ff <= inrange_in;
      tri_ff     <= tri_in;
      rsp_ff     <= rsp_in;
   end

   assign req_ready = (st_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/lodsg_checker.sv @@
// Port-level checks for the LOD stitching index generator, bound to the top.
// Depends on lodsg_pkg and lod_stitch_index_generator.
`default_nettype none

module lodsg_checker
   import lodsg_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp
);

   // a stalled result item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // a stalled result item keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp))
      else $error("result payload changed while stalled");

   // region codes stop at the interior fill
   a_region: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.region <= REGION_FILL))
      else $error("region code out of range");

   // out of reset: clearing pass, nothing offered, nothing taken
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block active right after reset");

   // a result never appears in the cycle after an input item is taken
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result item faster than the sequencer allows");

endmodule

bind lod_stitch_index_generator lodsg_checker u_lodsg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);

`default_nettype wire

@@ bench/tb_lod_stitch_index_generator.sv @@
`timescale 1ns / 1ps
// Testbench for lod_stitch_index_generator: a scoreboard class predicts every triangle
// of the chunk index list and checks the block's results in order.
// Depends on lodsg_pkg and the block's RTL only.

import lodsg_pkg::*;

class triangle_scoreboard;
   localparam int MAP_CELLS = (GRID_CELLS_DEF + 1) * (GRID_CELLS_DEF + 1);

   logic [LOD_W-1:0] level = '0;
   bit               done_map [MAP_CELLS];
   logic [3:0]       coarse = '0;
   phase_type        walk = PH_IDLE;
   int unsigned      col = 0;
   int unsigned      row = 0;
   int unsigned      tri_pos = 0;
   rsp_type          triangles_due [$];
   int unsigned      errors = 0;

   function int unsigned side();
      return GRID_CELLS_DEF >> ((level > LOD_MAX) ? LOD_MAX : level);
   endfunction

   function bit cell_taken(int unsigned cx, int unsigned cz);
      int unsigned w;
      w = side() + 1;
      if (cx >= w || cz >= w) return 1'b1;
      return done_map[cz * w + cx];
   endfunction

   function void take_cell(int unsigned cx, int unsigned cz);
      int unsigned w;
      w = side() + 1;
      if (cx < w && cz < w) done_map[cz * w + cx] = 1'b1;
   endfunction

   function void jump_to(phase_type p);
      walk = p;
      col  = 0;
      row  = 0;
   endfunction

   // move the cursor to the next group that yields triangles, or to done
   function void seek_group();
      int unsigned n;
      n = side();
      forever begin
         case (walk)
            PH_NORTH: begin
               if (!coarse[FLAG_NORTH] || col + 2 > n) jump_to(PH_SOUTH);
               else return;
            end
            PH_SOUTH: begin
               if (!coarse[FLAG_SOUTH] || col + 2 > n) jump_to(PH_EAST);
               else return;
            end
            PH_EAST: begin
               if (!coarse[FLAG_EAST] || row + 2 > n) jump_to(PH_WEST);
               else if (cell_taken(n - 2, row) || cell_taken(n - 1, row + 1)) row += 2;
               else return;
            end
            PH_WEST: begin
               if (!coarse[FLAG_WEST] || row + 2 > n) jump_to(PH_FILL);
               else if (cell_taken(0, row) || cell_taken(0, row + 1)) row += 2;
               else return;
            end
            PH_FILL: begin
               if (row >= n) begin
                  walk = PH_DONE;
                  return;
               end else if (col >= n) begin
                  col = 0;
                  row++;
               end else if (cell_taken(col, row)) begin
                  col++;
               end else begin
                  return;
               end
            end
            default: return;
         endcase
      end
   endfunction

   function void accept_request(req_type r);
      int unsigned lv, n, w, cx, cz, a, b, c, d, e, t0, t1, t2, group;
      rsp_type     shape;
      lv = 32'((level > LOD_MAX) ? LOD_MAX : level);
      if (r.func == FUNC_START) begin
         coarse[FLAG_NORTH] = 32'(r.lod_north) > lv;
         coarse[FLAG_SOUTH] = 32'(r.lod_south) > lv;
         coarse[FLAG_EAST]  = 32'(r.lod_east) > lv;
         coarse[FLAG_WEST]  = 32'(r.lod_west) > lv;
         foreach (done_map[i]) done_map[i] = 1'b0;
         jump_to(PH_NORTH);
         tri_pos = 0;
         seek_group();
         return;
      end
      if (walk == PH_IDLE || walk == PH_DONE) return;
      if (tri_pos == 0) seek_group();
      if (walk == PH_DONE) return;

      n = side();
      w = n + 1;
      group = 3;
      shape = '0;
      case (walk)
         PH_NORTH: begin
            cz = n - 1;
            cx = col;
            a = cx + cz * w; b = a + 1; c = a + 2;
            d = cx + (cz + 1) * w; e = d + 2;
            shape.region = REGION_NORTH;
            if (tri_pos == 0) {t0, t1, t2} = {a, d, b};
            else if (tri_pos == 1) {t0, t1, t2} = {b, d, e};
            else {t0, t1, t2} = {b, e, c};
         end
         PH_SOUTH: begin
            a = col; b = col + 2; c = col + w; d = c + 1; e = c + 2;
            shape.region = REGION_SOUTH;
            if (tri_pos == 0) {t0, t1, t2} = {a, c, d};
            else if (tri_pos == 1) {t0, t1, t2} = {a, d, b};
            else {t0, t1, t2} = {b, d, e};
         end
         PH_EAST: begin
            a = (n - 1) + row * w; b = a + w; c = b + w; d = a + 1; e = c + 1;
            shape.region = REGION_EAST;
            if (tri_pos == 0) {t0, t1, t2} = {a, b, d};
            else if (tri_pos == 1) {t0, t1, t2} = {b, e, d};
            else {t0, t1, t2} = {b, c, e};
         end
         PH_WEST: begin
            a = row * w; b = a + 2 * w; c = a + 1; d = a + w + 1; e = b + 1;
            shape.region = REGION_WEST;
            if (tri_pos == 0) {t0, t1, t2} = {a, d, c};
            else if (tri_pos == 1) {t0, t1, t2} = {a, b, d};
            else {t0, t1, t2} = {b, e, d};
         end
         default: begin
            a = row * w + col; b = a + 1; c = a + w; d = c + 1;
            group = 2;
            shape.region = REGION_FILL;
            if (tri_pos == 0) {t0, t1, t2} = {a, c, b};
            else {t0, t1, t2} = {b, c, d};
         end
      endcase
      shape.index_first  = t0[IDX_W-1:0];
      shape.index_second = t1[IDX_W-1:0];
      shape.index_third  = t2[IDX_W-1:0];

      tri_pos++;
      if (tri_pos >= group) begin
         tri_pos = 0;
         case (walk)
            PH_NORTH: begin
               take_cell(col, n - 1); take_cell(col + 1, n - 1);
               col += 2;
            end
            PH_SOUTH: begin
               take_cell(col, 0); take_cell(col + 1, 0);
               col += 2;
            end
            PH_EAST: begin
               take_cell(n - 1, row); take_cell(n - 1, row + 1);
               row += 2;
            end
            PH_WEST: begin
               take_cell(0, row); take_cell(0, row + 1);
               row += 2;
            end
            default: col++;
         endcase
         seek_group();
      end
      shape.last = (walk == PH_DONE);
      triangles_due = {triangles_due, shape};
   endfunction

   function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         if (errors < 200)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         errors++;
      end
   endfunction

   function void check_triangle(rsp_type got);
      rsp_type want;
      if (triangles_due.size() == 0) begin
         if (errors < 200)
            $display("%0t: unexpected triangle, expected none, actual %0d %0d %0d reg %0d last %0d",
                     $time, got.index_first, got.index_second, got.index_third,
                     got.region, got.last);
         errors++;
         return;
      end
      want = triangles_due.pop_front();
      compare_field("index_first", 32'(want.index_first), 32'(got.index_first));
      compare_field("index_second", 32'(want.index_second), 32'(got.index_second));
      compare_field("index_third", 32'(want.index_third), 32'(got.index_third));
      compare_field("region", 32'(want.region), 32'(got.region));
      compare_field("last", 32'(want.last), 32'(got.last));
   endfunction
endclass

module tb_lod_stitch_index_generator;
   // a start may trigger the map clearing pass; allow it plus the longest settle walk
   localparam int unsigned SETTLE_CYCLES = 5000;
   localparam int unsigned CYCLE_LIMIT   = 3000000;
   localparam int unsigned PHASE_ITEMS   = 150;
   localparam int unsigned PHASES        = 13;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp;
   logic             csr_wr_en = 1'b0;
   logic [LOD_W-1:0] csr_wr_data = '0;

   triangle_scoreboard board = new();

   int unsigned cycles = 0;
   bit          send_calm = 1'b0;
   bit          recv_calm = 1'b0;

   // settings walked by the random part, extremes and the clamped levels among them
   int unsigned phase_level [PHASES] = '{5, 3, 4, 0, 7, 2, 4, 6, 1, 3, 5, 4, 3};

   lod_stitch_index_generator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // check every triangle taken by the receiver against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_triangle(rsp);
      end
   end

   // receiver: random stalls per item, calm stretches, and two long hold-offs that back
   // the block up until its input stalls
   initial begin
      int unsigned gap;
      int unsigned seen;
      seen = 0;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
         gap = recv_calm ? 0 : $urandom_range(0, 6);
         if (seen == 100 || seen == 700) gap = 400;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
         seen++;
      end
   end

   function automatic req_type make_item(logic f);
      req_type r;
      r.func      = f;
      r.lod_north = LOD_W'($urandom_range(0, 7));
      r.lod_south = LOD_W'($urandom_range(0, 7));
      r.lod_east  = LOD_W'($urandom_range(0, 7));
      r.lod_west  = LOD_W'($urandom_range(0, 7));
      return r;
   endfunction

   // offer one item after a random gap; hold it until the block takes it
   task automatic send_item(input req_type item);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.accept_request(item);
   endtask

   // advance until the predicted list is complete or the budget runs out
   task automatic advance_to_end(inout int unsigned sent, input int unsigned budget);
      while (board.walk != PH_DONE && sent < budget) begin
         send_item(make_item(FUNC_ADVANCE));
         sent++;
      end
   endtask

   // drop valid, drain every expected triangle, then give the block time to finish
   // work that yields no triangle
   task automatic quiesce();
      req_valid <= 1'b0;
      while (board.triangles_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_level(input logic [LOD_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.level = value;
   endtask

   // mostly complete lists, some cut short by the next start, a little noise
   task automatic run_phase(input int unsigned budget);
      int unsigned sent;
      int unsigned roll;
      int unsigned extra;
      sent = 0;
      while (sent < budget) begin
         roll = $urandom_range(0, 9);
         if (roll == 9) begin
            extra = $urandom_range(1, 6);
            repeat (extra) send_item(make_item(1'($urandom_range(0, 1))));
            sent += extra;
         end else begin
            send_item(make_item(FUNC_START));
            sent++;
            if (roll < 7) begin
               advance_to_end(sent, budget);
               // advances past the last triangle are ignored
               extra = $urandom_range(0, 2);
               repeat (extra) send_item(make_item(FUNC_ADVANCE));
               sent += extra;
            end else begin
               extra = $urandom_range(0, 2 * board.side());
               repeat (extra) send_item(make_item(FUNC_ADVANCE));
               sent += extra;
            end
         end
      end
   endtask

   initial begin
      int unsigned sent;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // full-size grid from reset: advances before any start yield nothing
      sent = 0;
      send_item(make_item(FUNC_ADVANCE));
      send_item(make_item(FUNC_ADVANCE));
      // every neighbour coarser: north fans first
      send_item(req_type'{FUNC_START, 3'd7, 3'd7, 3'd7, 3'd7});
      repeat (4) send_item(make_item(FUNC_ADVANCE));
      // no neighbour coarser: straight to interior fill
      send_item(req_type'{FUNC_START, 3'd0, 3'd0, 3'd0, 3'd0});
      repeat (2) send_item(make_item(FUNC_ADVANCE));
      quiesce();

      // smallest grid: north and south fans, skipped east and west pairs, last flag
      write_level(3'd5);
      send_item(req_type'{FUNC_START, 3'd7, 3'd7, 3'd7, 3'd7});
      advance_to_end(sent, 100);
      send_item(make_item(FUNC_ADVANCE));
      // neighbours at the same level are not coarser
      send_item(req_type'{FUNC_START, 3'd6, 3'd5, 3'd7, 3'd0});
      sent = 0;
      advance_to_end(sent, 100);
      quiesce();

      // random part; lists left open carry over into the next level
      for (int p = 0; p < PHASES; p++) begin
         write_level(phase_level[p]);
         run_phase(PHASE_ITEMS);
         quiesce();
      end

      if (board.errors == 0 && board.triangles_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
